// ===== rtl/hbf_pkg.sv =====
// Shared types and constants for the HUB75 bitplane word formatter.
// No dependencies; compiled first.
package hbf_pkg;

    localparam int ColorBits   = 8;
    localparam int PlaneWords  = 7;
    localparam int WordBits    = 13;
    localparam int AddrBits    = 10;
    localparam int ColumnBits  = 6;
    localparam int RowBits     = 4;
    localparam int BrBits      = 6;
    localparam int RowCodeBits = 5;
    localparam int LatchBit    = 11;
    localparam int OeNBit      = 12;
    localparam int CfgIdxBits  = 1;
    localparam int CfgDataBits = 6;

    localparam logic [BrBits-1:0] BrightnessReset = 6'd2;
    localparam logic [BrBits-1:0] LowPowerReset   = 6'd20;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_BRIGHTNESS     = 1'b0,
        REG_BRIGHTNESS_CAP = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [BrBits-1:0] brightness;
        logic [BrBits-1:0] brightness_cap;
    } t_cfg;

    typedef struct packed {
        logic [ColumnBits-1:0]  column;
        logic [RowBits-1:0]     row;
        logic [3*ColorBits-1:0] upper_color;
        logic [3*ColorBits-1:0] lower_color;
        logic                   power_bad;
    } t_pix;

    typedef struct packed {
        logic [AddrBits-1:0] word_address;
        logic [WordBits-1:0] plane_word_0;
        logic [WordBits-1:0] plane_word_1;
        logic [WordBits-1:0] plane_word_2;
        logic [WordBits-1:0] plane_word_3;
        logic [WordBits-1:0] plane_word_4;
        logic [WordBits-1:0] plane_word_5;
        logic [WordBits-1:0] plane_word_6;
    } t_word;

endpackage

// ===== rtl/hbf_pix_if.sv =====
// Pixel pair channel: valid/ready handshake carrying one t_pix beat.
// Depends on hbf_pkg.
interface hbf_pix_if;
    logic             valid;
    logic             ready;
    hbf_pkg::t_pix    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hbf_word_if.sv =====
// Panel word channel: valid/ready handshake carrying one t_word beat.
// Depends on hbf_pkg.
interface hbf_word_if;
    logic             valid;
    logic             ready;
    hbf_pkg::t_word   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hbf_cfg.sv =====
// Configuration registers: brightness (saturated) and low-power cap.
// Depends on hbf_pkg.
module hbf_cfg #(
    parameter int PANEL_WIDTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hbf_pkg::CfgIdxBits-1:0]  i_cfg_idx,
    input  logic [hbf_pkg::CfgDataBits-1:0] i_cfg_data,
    output hbf_pkg::t_cfg                   o_cfg
);
    import hbf_pkg::*;

    localparam int BrMax = PANEL_WIDTH - 2;

    t_cfg              r_cfg;
    t_cfg              n_cfg;
    logic [BrBits-1:0] w_br_sat;

    // clamp to PANEL_WIDTH - 2, a window that still leaves the latch column dark
    assign w_br_sat = (int'(i_cfg_data) > BrMax) ? BrBits'(BrMax) : BrBits'(i_cfg_data);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_BRIGHTNESS:     n_cfg.brightness     = w_br_sat;
                REG_BRIGHTNESS_CAP: n_cfg.brightness_cap = BrBits'(i_cfg_data);
                default:            n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness     <= BrightnessReset;
            r_cfg.brightness_cap <= LowPowerReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/hbf_enc.sv =====
// Combinational encoder: address, OE window, latch, row code and plane bits.
// Depends on hbf_pkg.
module hbf_enc #(
    parameter int PANEL_WIDTH = 64,
    parameter int PLANE_COUNT = 7
) (
    input  hbf_pkg::t_cfg  i_cfg,
    input  hbf_pkg::t_pix  i_pix,
    output hbf_pkg::t_word o_word
);
    import hbf_pkg::*;

    // wide enough for PANEL_WIDTH + brightness
    localparam int SpanBits = $clog2(PANEL_WIDTH + 64);

    logic [BrBits-1:0]      w_br;
    logic [SpanBits-1:0]    w_start;
    logic [SpanBits-1:0]    w_stop;
    logic [SpanBits-1:0]    w_disp;
    logic                   w_in_win;
    logic                   w_latch;
    logic [RowCodeBits-1:0] w_row_code;
    logic [WordBits-1:0]    w_plane [PlaneWords];

    assign w_br = (i_pix.power_bad && (i_cfg.brightness > i_cfg.brightness_cap))
                ? i_cfg.brightness_cap : i_cfg.brightness;

    assign w_start = (SpanBits'(PANEL_WIDTH) - SpanBits'(w_br)) >> 1;
    assign w_stop  = (SpanBits'(PANEL_WIDTH) + SpanBits'(w_br)) >> 1;

    // FIFO swaps columns pairwise
    assign w_disp     = SpanBits'(i_pix.column ^ ColumnBits'(1));
    assign w_in_win   = (w_disp >= w_start) && (w_disp < w_stop);
    assign w_latch    = (w_disp == SpanBits'(PANEL_WIDTH - 1));
    assign w_row_code = RowCodeBits'(i_pix.row) - RowCodeBits'(1);

    for (genvar p = 0; p < PlaneWords; p++) begin : g_plane
        if (p < PLANE_COUNT) begin : g_used
            localparam int Bit = ColorBits - PLANE_COUNT + p;
            assign w_plane[p] = {
                ~w_in_win, w_latch, w_row_code,
                i_pix.lower_color[Bit], i_pix.lower_color[ColorBits+Bit],
                i_pix.lower_color[2*ColorBits+Bit],
                i_pix.upper_color[Bit], i_pix.upper_color[ColorBits+Bit],
                i_pix.upper_color[2*ColorBits+Bit]
            };
        end else begin : g_unused
            assign w_plane[p] = '0;
        end
    end

    assign o_word.word_address = AddrBits'(int'(i_pix.row) * PANEL_WIDTH
                                           + int'(i_pix.column));
    assign o_word.plane_word_0 = w_plane[0];
    assign o_word.plane_word_1 = w_plane[1];
    assign o_word.plane_word_2 = w_plane[2];
    assign o_word.plane_word_3 = w_plane[3];
    assign o_word.plane_word_4 = w_plane[4];
    assign o_word.plane_word_5 = w_plane[5];
    assign o_word.plane_word_6 = w_plane[6];

endmodule

// ===== rtl/hub75_bitplane_word_formatter_unit.sv =====
// HUB75 bitplane word formatter, top level.
// Word beat: an accepted pixel beat is encoded from the input register into the result register.
// Throughput: one beat per cycle; input register -> encoder -> result register,
// each stage moves whenever the stage after it is empty or being drained.
// Reset (synchronous, active low): both stages empty, brightness 2, cap 20.
// Depends on hbf_pkg, hbf_pix_if, hbf_word_if, hbf_cfg, hbf_enc.
module hub75_bitplane_word_formatter_unit #(
    parameter int PANEL_WIDTH = 64,
    parameter int PLANE_COUNT = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hbf_pix_if.sink                         i_pix,
    hbf_word_if.source                      o_word,
    input  logic                            i_cfg_we,
    input  logic [hbf_pkg::CfgIdxBits-1:0]  i_cfg_idx,
    input  logic [hbf_pkg::CfgDataBits-1:0] i_cfg_data
);
    import hbf_pkg::*;

    t_cfg  w_cfg;
    t_pix  r_pix;
    t_word w_word;
    t_word r_word;
    logic  r_v1;
    logic  n_v1;
    logic  r_v2;
    logic  n_v2;
    logic  w_s1_ready;
    logic  w_s2_ready;

    hbf_cfg #(
        .PANEL_WIDTH (PANEL_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // encoder sits between the input register and the result register
    hbf_enc #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PLANE_COUNT (PLANE_COUNT)
    ) u_enc (
        .i_cfg  (w_cfg),
        .i_pix  (r_pix),
        .o_word (w_word)
    );

    // a stage may load when empty or when its beat leaves this cycle
    assign w_s2_ready = !r_v2 || o_word.ready;
    assign w_s1_ready = !r_v1 || w_s2_ready;
    assign i_pix.ready = w_s1_ready;

    assign n_v1 = w_s1_ready ? i_pix.valid : r_v1;
    assign n_v2 = w_s2_ready ? r_v1 : r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_pix.valid) begin
            r_pix <= i_pix.data;
        end
        if (w_s2_ready && r_v1) begin
            r_word <= w_word;
        end
    end

    assign o_word.valid = r_v2;
    assign o_word.data  = r_word;

    // a loaded input stage always reaches the result register when it is free
    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_s2_ready |=> r_v2)
        else $error("input stage beat did not advance");

    // brightness is held within the panel after saturation
    a_br_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_cfg.brightness) <= PANEL_WIDTH - 2 || PANEL_WIDTH - 2 > 63)
        else $error("brightness exceeds panel width");

    // the latch column always lies outside the enable window
    a_latch_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_word.plane_word_0[LatchBit] |-> r_word.plane_word_0[OeNBit])
        else $error("latch asserted with output enabled");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2)
        else $error("pipeline not empty after reset");

endmodule
